// ===== rtl/core/fsh_pkg.sv =====
// Shared constants, types and the fold helper for the Fletcher-32 string hash.
`default_nettype none

package fsh_pkg;

  localparam int unsigned SUM_W = 32;
  localparam int unsigned CNT_W = 9;

  localparam logic [SUM_W-1:0] SUM_INIT    = 32'h0000_ffff;
  localparam logic [7:0]       PAD_BYTE    = 8'h25;
  localparam logic [CNT_W-1:0] BLOCK_WORDS = 9'd360;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Sums handed from the accumulator to the finishing stage at message end.
  typedef struct packed {
    sum_t first_sum;
    sum_t second_sum;
    logic block_open;
  } fin_req_t;

  // Adds the high half of a sum into its low half.
  function automatic sum_t fold16(input sum_t s);
    logic [16:0] r;
    r = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    return {15'b0, r};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fletcher32_string_hash_unit.sv =====
// Fletcher-32 hash of a byte string: top level joining accumulator and finishing stage.
// Throughput: one byte per cycle, including back-to-back messages, while the finishing stage
// takes each last byte. After the last byte is accepted, the hash passes the accumulator step
// into the finishing register, then the final folds into the output register; a hash held by
// the receiver stalls the next last byte until a stage frees.
// Reset (synchronous, active high) empties all stages and restores both sums to 0xffff.
`default_nettype none

module fletcher32_string_hash_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last_byte,
  output logic             hash_valid,
  input  wire logic        hash_ready,
  output logic [31:0]      hash_value
);

  logic              fin_valid;
  logic              fin_ready;
  fsh_pkg::fin_req_t fin_req;

  fsh_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .fin_valid    (fin_valid),
    .fin_ready    (fin_ready),
    .fin_req      (fin_req)
  );

  fsh_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .fin_valid  (fin_valid),
    .fin_ready  (fin_ready),
    .fin_req    (fin_req),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire

// ===== rtl/core/fsh_accum.sv =====
// Input register, byte pairing and running Fletcher sums with block folding.
`default_nettype none

module fsh_accum (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire logic [7:0]       data_byte,
  input  wire logic             byte_present,
  input  wire logic             last_byte,
  output logic                  fin_valid,
  input  wire logic             fin_ready,
  output fsh_pkg::fin_req_t     fin_req
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             in_present;
  logic             in_last;

  logic [7:0]       low_half_byte;
  logic             half_pending;
  fsh_pkg::sum_t    first_sum;
  fsh_pkg::sum_t    second_sum;
  fsh_pkg::cnt_t    words_in_block;

  logic             proc;
  logic             add_pair;
  logic             add_pad;
  logic [15:0]      word;
  fsh_pkg::sum_t    s1_add;
  fsh_pkg::sum_t    s2_add;
  fsh_pkg::cnt_t    cnt_inc;
  fsh_pkg::sum_t    first_sum_next;
  fsh_pkg::sum_t    second_sum_next;
  fsh_pkg::cnt_t    words_in_block_next;

  // A last item needs the finishing stage free; other items never stall.
  assign proc       = in_full && (!in_last || fin_ready);
  assign item_ready = !in_full || proc;
  assign fin_valid  = in_full && in_last;

  always_comb begin
    add_pair = in_present && half_pending;
    // A message of odd length ends with its lone byte padded in the high half.
    add_pad  = in_last && (in_present != half_pending);
    word     = {(add_pair ? in_byte : fsh_pkg::PAD_BYTE),
                (half_pending ? low_half_byte : in_byte)};
    s1_add   = first_sum + {16'b0, word};
    s2_add   = second_sum + s1_add;
    cnt_inc  = words_in_block + 9'd1;

    first_sum_next      = first_sum;
    second_sum_next     = second_sum;
    words_in_block_next = words_in_block;
    if (add_pair || add_pad) begin
      if (cnt_inc >= fsh_pkg::BLOCK_WORDS) begin
        first_sum_next      = fsh_pkg::fold16(s1_add);
        second_sum_next     = fsh_pkg::fold16(s2_add);
        words_in_block_next = '0;
      end else begin
        first_sum_next      = s1_add;
        second_sum_next     = s2_add;
        words_in_block_next = cnt_inc;
      end
    end

    fin_req.first_sum  = first_sum_next;
    fin_req.second_sum = second_sum_next;
    fin_req.block_open = (words_in_block_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
    if (item_ready && item_valid) begin
      in_byte    <= data_byte;
      in_present <= byte_present;
      in_last    <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_half_byte  <= '0;
      half_pending   <= 1'b0;
      first_sum      <= fsh_pkg::SUM_INIT;
      second_sum     <= fsh_pkg::SUM_INIT;
      words_in_block <= '0;
    end else if (proc) begin
      if (in_last) begin
        low_half_byte  <= '0;
        half_pending   <= 1'b0;
        first_sum      <= fsh_pkg::SUM_INIT;
        second_sum     <= fsh_pkg::SUM_INIT;
        words_in_block <= '0;
      end else begin
        if (in_present) begin
          half_pending <= !half_pending;
          if (!half_pending) begin
            low_half_byte <= in_byte;
          end
        end
        first_sum      <= first_sum_next;
        second_sum     <= second_sum_next;
        words_in_block <= words_in_block_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsh_finish.sv =====
// Final folds of both sums and the registered hash output.
`default_nettype none

module fsh_finish (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fin_valid,
  output logic                  fin_ready,
  input  wire fsh_pkg::fin_req_t fin_req,
  output logic                  hash_valid,
  input  wire logic             hash_ready,
  output logic [31:0]           hash_value
);

  logic              req_full;
  fsh_pkg::fin_req_t req;
  logic              req_move;
  logic              out_load;
  fsh_pkg::sum_t     s1_a;
  fsh_pkg::sum_t     s2_a;
  fsh_pkg::sum_t     s1_b;
  fsh_pkg::sum_t     s2_b;
  logic [31:0]       hash_next;

  assign out_load  = !hash_valid || hash_ready;
  assign req_move  = req_full && out_load;
  assign fin_ready = !req_full || req_move;

  always_comb begin
    // An unfinished block is folded first; one more fold always follows.
    s1_a = req.block_open ? fsh_pkg::fold16(req.first_sum)  : req.first_sum;
    s2_a = req.block_open ? fsh_pkg::fold16(req.second_sum) : req.second_sum;
    s1_b = fsh_pkg::fold16(s1_a);
    s2_b = fsh_pkg::fold16(s2_a);
    hash_next = {s2_b[15:0], 16'b0} | s1_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full   <= 1'b0;
      hash_valid <= 1'b0;
    end else begin
      if (fin_ready) begin
        req_full <= fin_valid;
      end
      if (out_load) begin
        hash_valid <= req_full;
      end
    end
    if (fin_ready && fin_valid) begin
      req <= fin_req;
    end
    if (req_move) begin
      hash_value <= hash_next;
    end
  end

endmodule

`default_nettype wire
